// ===== rtl/mcfdl_pkg.sv =====
// Shared widths, register indexes and reset values for the current foldback duty limiter.
`default_nettype none
package mcfdl_pkg;
  localparam int unsigned TickMs = 10;

  localparam int unsigned CurW  = 12;
  localparam int unsigned VdW   = 17;
  localparam int unsigned VbW   = 16;
  localparam int unsigned DutyW = 17;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned TmrW  = 16;

  // Scaled numerator (N * limit) and divisor (Vbat * I) widths.
  localparam int unsigned NumW = 41;
  localparam int unsigned DenW = 28;

  localparam logic [IdxW-1:0] RegBoostCurrent = 3'd0;
  localparam logic [IdxW-1:0] RegNormalLimit  = 3'd1;
  localparam logic [IdxW-1:0] RegFbThreshold  = 3'd2;
  localparam logic [IdxW-1:0] RegFbLimit      = 3'd3;
  localparam logic [IdxW-1:0] RegBoostDur     = 3'd4;
  localparam logic [IdxW-1:0] RegFbTrigger    = 3'd5;
  localparam logic [IdxW-1:0] RegCoolDown     = 3'd6;
  localparam logic [IdxW-1:0] RegResistance   = 3'd7;

  localparam logic [CurW-1:0] RstBoostCurrent = 12'd1600;
  localparam logic [CurW-1:0] RstNormalLimit  = 12'd1280;
  localparam logic [CurW-1:0] RstFbThreshold  = 12'd1008;
  localparam logic [CurW-1:0] RstFbLimit      = 12'd768;
  localparam logic [TmrW-1:0] RstBoostDur     = 16'd2000;
  localparam logic [TmrW-1:0] RstFbTrigger    = 16'd10000;
  localparam logic [TmrW-1:0] RstCoolDown     = 16'd50000;
  localparam logic [TmrW-1:0] RstResistance   = 16'd50;

  localparam logic [DutyW-1:0] DutyFull = 17'd65536;
endpackage
`default_nettype wire

// ===== rtl/mcfdl_div.sv =====
// Bit-serial restoring divider for the duty quotient, saturating at full duty.
`default_nettype none
module mcfdl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mcfdl_pkg::NumW-1:0]    num_i,
  input  wire logic [mcfdl_pkg::DenW-1:0]    den_i,
  output logic                               done_o,
  output logic [mcfdl_pkg::DutyW-1:0]        quo_o
);
  localparam int unsigned DW = mcfdl_pkg::DenW;
  localparam int unsigned QW = mcfdl_pkg::DutyW;

  logic            busy_q, busy_d, done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [DW-1:0]   rem_q, rem_d, den_q, den_d;
  logic [QW-1:0]   sh_q, sh_d, quo_q, quo_d;
  logic [DW:0]     trial;
  logic            ge;
  logic [35:0]     top_bits;

  // Quotient below 2^17 exactly when num / 32 < den.
  assign top_bits = num_i[mcfdl_pkg::NumW-1:5];
  assign trial    = {rem_q, sh_q[QW-1]};
  assign ge       = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = den_i;
      if (top_bits >= {8'd0, den_i}) begin
        quo_d  = mcfdl_pkg::DutyFull;
        done_d = 1'b1;
      end else begin
        rem_d  = top_bits[DW-1:0];
        sh_d   = {num_i[4:0], 12'd0};
        quo_d  = '0;
        cnt_d  = 5'(QW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      sh_d  = {sh_q[QW-2:0], 1'b0};
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q > mcfdl_pkg::DutyFull) ? mcfdl_pkg::DutyFull : quo_q;
endmodule
`default_nettype wire

// ===== rtl/motor_current_foldback_duty_limiter_top.sv =====
// Top level of the motor current foldback duty limiter with IR compensation.
// Usage:
//   One input item per control tick on the s_axis group: tdata carries the
//   measured current (1/16 A), the signed desired voltage (mV) and the
//   battery voltage (mV). One result item leaves on m_axis: the Q1.16 duty,
//   the protection mode after this tick's update and the limit in force.
//   The protection machine (normal, boost, foldback) steps first; the duty
//   then follows from the new mode and limit.
// Timing: most of an item's time from acceptance to result is spent in
//   the bit-serial divider, which resolves one quotient bit a cycle over 17
//   bits. A quotient that would pass full duty skips the bit loop. Items
//   with no positive drive or a zero battery skip the divider. One item is
//   in work at a time: the next item can be accepted in the cycle after the
//   result is registered.
// Stall: the result sits in an output register; the next item is taken
//   while it waits, and finishes into that register once it is taken.
// Reset: config registers go to their documented values, the mode to normal,
//   timers to zero and the active limit to the normal limit reset value.
// Config: write cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle.
`default_nettype none
module motor_current_foldback_duty_limiter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] measured_current, [28:12] desired_voltage, [44:29] battery_voltage
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [16:0] duty, [18:17] protection_mode, [30:19] active_limit
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [mcfdl_pkg::CfgW-1:0] cfg_data_i
);
  localparam logic [1:0] ModeNormal   = 2'd0;
  localparam logic [1:0] ModeBoost    = 2'd1;
  localparam logic [1:0] ModeFoldback = 2'd2;
  localparam logic [16:0] TickAdd = 17'(mcfdl_pkg::TickMs);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_SUM, S_SCALE, S_GO, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [11:0] bc_q, nl_q, thr_q, fl_q;
  logic [15:0] dur_q, trig_q, cool_q, res_q;

  // Protection state.
  logic [1:0]  mode_q, mode_d;
  logic [15:0] boost_q, boost_d, fb_q, fb_d;
  logic [11:0] lim_q, lim_d;

  // Item datapath.
  logic [11:0] cur_q;
  logic signed [16:0] vd_q;
  logic [15:0] vb_q;
  logic [27:0] ir_q, cap_q, den_q;
  logic        scale_q;
  logic signed [29:0] n_q;
  logic [40:0] num_q;
  logic [16:0] duty_q;
  logic        go_div;
  logic        div_done;
  logic [16:0] div_quo;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        slot_free;

  logic signed [20:0] v16;
  logic signed [29:0] v16c;
  logic [16:0] s_fb;

  assign s_axis_tready = (state_q == S_IDLE);
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign go_div        = (state_q == S_GO);

  function automatic logic [15:0] sat_add(input logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + TickAdd;
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Protection update for the current item.
  always_comb begin
    mode_d  = mode_q;
    boost_d = boost_q;
    fb_d    = fb_q;
    lim_d   = lim_q;
    s_fb    = '0;
    if (mode_q != ModeFoldback && cur_q >= thr_q) begin
      fb_d = sat_add(fb_q);
    end else if (mode_q != ModeFoldback) begin
      fb_d = '0;
    end
    if (mode_q != ModeFoldback && cur_q >= thr_q && fb_d >= trig_q) begin
      // Enter foldback and skip the rest of the update.
      mode_d  = ModeFoldback;
      lim_d   = fl_q;
      fb_d    = cool_q;
      boost_d = '0;
    end else if (mode_q == ModeBoost) begin
      boost_d = sat_add(boost_q);
      if (boost_d >= dur_q) begin
        mode_d = ModeNormal;
        lim_d  = nl_q;
      end
    end else if (mode_q == ModeFoldback) begin
      if (fb_q != '0) begin
        s_fb = {1'b0, fb_q} - TickAdd;
        fb_d = s_fb[16] ? '0 : s_fb[15:0];
      end else begin
        mode_d = ModeNormal;
        lim_d  = nl_q;
      end
    end else begin
      mode_d = ModeNormal;
      if (cur_q > bc_q) begin
        mode_d  = ModeBoost;
        boost_d = '0;
        lim_d   = bc_q;
      end
    end
  end

  assign v16  = 21'(vd_q) <<< 4;
  assign v16c = (mode_q == ModeFoldback && 30'(v16) > $signed({2'b00, cap_q}))
                ? $signed({2'b00, cap_q}) : 30'(v16);

  mcfdl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_div),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= mcfdl_pkg::RstBoostCurrent;
      nl_q   <= mcfdl_pkg::RstNormalLimit;
      thr_q  <= mcfdl_pkg::RstFbThreshold;
      fl_q   <= mcfdl_pkg::RstFbLimit;
      dur_q  <= mcfdl_pkg::RstBoostDur;
      trig_q <= mcfdl_pkg::RstFbTrigger;
      cool_q <= mcfdl_pkg::RstCoolDown;
      res_q  <= mcfdl_pkg::RstResistance;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcfdl_pkg::RegBoostCurrent: bc_q   <= cfg_data_i[11:0];
        mcfdl_pkg::RegNormalLimit:  nl_q   <= cfg_data_i[11:0];
        mcfdl_pkg::RegFbThreshold:  thr_q  <= cfg_data_i[11:0];
        mcfdl_pkg::RegFbLimit:      fl_q   <= cfg_data_i[11:0];
        mcfdl_pkg::RegBoostDur:     dur_q  <= cfg_data_i;
        mcfdl_pkg::RegFbTrigger:    trig_q <= cfg_data_i;
        mcfdl_pkg::RegCoolDown:     cool_q <= cfg_data_i;
        mcfdl_pkg::RegResistance:   res_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, protection state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= ModeNormal;
      boost_q     <= '0;
      fb_q        <= '0;
      lim_q       <= mcfdl_pkg::RstNormalLimit;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the held result once taken, unless a new one replaces it.
      if (m_axis_tready && !(state_q == S_OUT && slot_free)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (s_axis_tvalid) state_q <= S_UPD;
        S_UPD: begin
          mode_q  <= mode_d;
          boost_q <= boost_d;
          fb_q    <= fb_d;
          lim_q   <= lim_d;
          state_q <= S_SUM;
        end
        S_SUM: state_q <= S_SCALE;
        S_SCALE: begin
          // Skip the divider when there is no drive or no battery reading.
          if (n_q <= 0 || vb_q == '0) state_q <= S_OUT;
          else state_q <= S_GO;
        end
        S_GO: state_q <= S_DIV;
        S_DIV: if (div_done) state_q <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      cur_q <= s_axis_tdata[11:0];
      vd_q  <= $signed(s_axis_tdata[28:12]);
      vb_q  <= s_axis_tdata[44:29];
    end
    if (state_q == S_UPD) begin
      ir_q    <= {16'd0, cur_q} * {12'd0, res_q};
      cap_q   <= {16'd0, fl_q} * {12'd0, res_q};
      scale_q <= cur_q > lim_d;
      den_q   <= (cur_q > lim_d) ? ({12'd0, vb_q} * {16'd0, cur_q}) : {12'd0, vb_q};
    end
    if (state_q == S_SUM) begin
      n_q <= v16c + $signed({2'b00, ir_q});
    end
    if (state_q == S_SCALE) begin
      num_q  <= scale_q ? ({12'd0, n_q[28:0]} * {29'd0, lim_q}) : {12'd0, n_q[28:0]};
      duty_q <= (n_q <= 0) ? '0 : mcfdl_pkg::DutyFull;
    end
    if (state_q == S_DIV && div_done) duty_q <= div_quo;
    if (state_q == S_OUT && slot_free) begin
      out_data_q <= {1'b0, lim_q, mode_q, duty_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Duty never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= mcfdl_pkg::DutyFull))
    else $error("duty above full scale");

  // Only one item in work: no new acceptance right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // Divider completes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider done outside wait state");
endmodule
`default_nettype wire

// ===== bench/motor_current_foldback_duty_limiter_checker.sv =====
// Checker for the foldback duty limiter: tracks config writes, predicts each result, compares.
`timescale 1ns / 100ps
module motor_current_foldback_duty_limiter_checker
  import mcfdl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef enum logic [1:0] {ModeNormal = 2'd0, ModeBoost = 2'd1, ModeFoldback = 2'd2} mode_e;

  typedef struct packed {
    logic [11:0]      limit;
    logic [1:0]       mode;
    logic [DutyW-1:0] duty;
  } duty_result_t;

  logic [CurW-1:0] boost_cur, norm_lim, fb_thr, fb_lim;
  logic [TmrW-1:0] boost_dur, fb_trig, cool_dn, res_mohm;
  mode_e           mode_q;
  logic [TmrW-1:0] boost_el, fb_cnt;
  logic [CurW-1:0] lim_now;
  duty_result_t    duty_queue[$];

  function automatic logic [TmrW-1:0] sat_up(logic [TmrW-1:0] a);
    return (a > 16'hFFFF - TickMs) ? 16'hFFFF : a + TickMs;
  endfunction

  // Step the protection machine; foldback entry ends the update for that tick.
  task automatic step_protection(input logic [CurW-1:0] cur);
    if (mode_q != ModeFoldback) begin
      if (cur >= fb_thr) begin
        fb_cnt = sat_up(fb_cnt);
        if (fb_cnt >= fb_trig) begin
          mode_q   = ModeFoldback;
          lim_now  = fb_lim;
          fb_cnt   = cool_dn;
          boost_el = '0;
          return;
        end
      end else begin
        fb_cnt = '0;
      end
    end
    if (mode_q == ModeBoost) begin
      boost_el = sat_up(boost_el);
      if (boost_el >= boost_dur) begin
        mode_q  = ModeNormal;
        lim_now = norm_lim;
      end
    end else if (mode_q == ModeFoldback) begin
      if (fb_cnt != 0) begin
        fb_cnt = (fb_cnt > TickMs) ? fb_cnt - TickMs : '0;
      end else begin
        mode_q  = ModeNormal;
        lim_now = norm_lim;
      end
    end else begin
      mode_q = ModeNormal;
      if (cur > boost_cur) begin
        mode_q   = ModeBoost;
        boost_el = '0;
        lim_now  = boost_cur;
      end
    end
  endtask

  function automatic logic [DutyW-1:0] calc_duty(logic [CurW-1:0] cur,
                                                 logic signed [VdW-1:0] vdes,
                                                 logic [VbW-1:0] vbat);
    longint v16, ir, n, cap;
    longint unsigned num, den, q;
    v16 = longint'(vdes) * 16;
    ir  = longint'(cur) * longint'(res_mohm);
    if (mode_q == ModeFoldback) begin
      cap = longint'(fb_lim) * longint'(res_mohm);
      if (v16 > cap) v16 = cap;
    end
    n = v16 + ir;
    if (n <= 0) return '0;
    if (vbat == 0) return DutyFull;
    num = longint'(n) * 4096;
    den = vbat;
    if (cur > lim_now) begin
      num = num * lim_now;
      den = den * cur;
    end
    q = num / den;
    return (q > 65536) ? DutyFull : q[DutyW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    duty_result_t exp_r, got_r;
    logic [CurW-1:0] cur;
    if (!rst_ni) begin
      boost_cur = RstBoostCurrent; norm_lim = RstNormalLimit;
      fb_thr = RstFbThreshold; fb_lim = RstFbLimit;
      boost_dur = RstBoostDur; fb_trig = RstFbTrigger;
      cool_dn = RstCoolDown; res_mohm = RstResistance;
      mode_q = ModeNormal; boost_el = '0; fb_cnt = '0; lim_now = RstNormalLimit;
      duty_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBoostCurrent: boost_cur = cfg_data_i[11:0];
          RegNormalLimit:  norm_lim  = cfg_data_i[11:0];
          RegFbThreshold:  fb_thr    = cfg_data_i[11:0];
          RegFbLimit:      fb_lim    = cfg_data_i[11:0];
          RegBoostDur:     boost_dur = cfg_data_i;
          RegFbTrigger:    fb_trig   = cfg_data_i;
          RegCoolDown:     cool_dn   = cfg_data_i;
          RegResistance:   res_mohm  = cfg_data_i;
          default: ;
        endcase
      end
      // Check output before queueing, since an input never completes in the cycle it is accepted.
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata[30:0];
        if (duty_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got_r);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = duty_queue.pop_front();
          if (got_r.duty !== exp_r.duty || got_r.mode !== exp_r.mode
              || got_r.limit !== exp_r.limit) begin
            $display("%0t: mismatch expected duty=%0d mode=%0d limit=%0d,",
                     $time, exp_r.duty, exp_r.mode, exp_r.limit,
                     " actual duty=%0d mode=%0d limit=%0d",
                     got_r.duty, got_r.mode, got_r.limit);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cur = s_axis_tdata[11:0];
        step_protection(cur);
        exp_r.duty  = calc_duty(cur, s_axis_tdata[28:12], s_axis_tdata[44:29]);
        exp_r.mode  = mode_q;
        exp_r.limit = lim_now;
        duty_queue.push_back(exp_r);
      end
      pending_o <= duty_queue.size();
    end
  end
endmodule

// ===== bench/motor_current_foldback_duty_limiter_top_tb.sv =====
// Testbench top: drives ticks and config writes into the duty limiter, gives the verdict.
`timescale 1ns / 100ps
module motor_current_foldback_duty_limiter_top_tb;
  import mcfdl_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [11:0] measured_current, [28:12] desired_voltage, [44:29] battery_voltage
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [16:0] duty, [18:17] protection_mode, [30:19] active_limit
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  motor_current_foldback_duty_limiter_top dut (.*);

  motor_current_foldback_duty_limiter_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: stall at the current idle rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one tick; drop valid only after acceptance, possibly idling afterwards.
  task automatic send_tick(input logic [11:0] cur, input logic [16:0] vd, input logic [15:0] vb);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b0, vb, vd, cur};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait out the queue and the block's tail, then let config change.
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Random tick with drive biased toward realistic values; currents cluster near thresholds.
  task automatic random_tick();
    logic [11:0] cur;
    logic [16:0] vd;
    logic [15:0] vb;
    case ($urandom_range(3))
      0: cur = $urandom_range(4095);
      1: cur = $urandom_range(1400, 1800);
      2: cur = $urandom_range(900, 1300);
      default: cur = $urandom_range(200);
    endcase
    vd = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 30000));
    if ($urandom_range(9) == 0) vd = -$urandom_range(65535);
    vb = ($urandom_range(19) == 0) ? 16'($urandom_range(1)) : 16'($urandom);
    if (vb == 0) vb = 16'($urandom_range(1, 65535));
    send_tick(cur, vd, vb);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes at reset configuration.
    send_idle_pct = 11; recv_idle_pct = 75;
    send_tick(12'd0, 17'd0, 16'd1);
    send_tick(12'hFFF, 17'h0FFFF, 16'hFFFF);
    send_tick(12'hFFF, 17'h10001, 16'd1);
    send_tick(12'd100, 17'h10000, 16'd1000);
    send_tick(12'd0, 17'h0FFFF, 16'd1);
    send_tick(12'd1700, 17'd12000, 16'd24000);
    send_tick(12'd1000, 17'd12000, 16'd24000);
    drain_all();

    // Short timers: boost expiry, quick foldback, zero cool-down, resistance extremes.
    write_reg(RegBoostDur, 16'd20);
    write_reg(RegFbTrigger, 16'd30);
    write_reg(RegCoolDown, 16'd0);
    write_reg(RegResistance, 16'hFFFF);
    write_reg(RegFbLimit, 16'd0);
    for (int i = 0; i < 8; i++) send_tick(12'(2000 + i), 17'd5000, 16'd12000);
    drain_all();
    write_reg(RegCoolDown, 16'd35);
    write_reg(RegFbLimit, 16'hFFF);
    write_reg(RegResistance, 16'd0);
    for (int i = 0; i < 10; i++) send_tick(12'hFFF, 17'h0FFFF, 16'd40000);
    drain_all();

    // Random phases across several settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 75; recv_idle_pct = 11; end
      if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      write_reg(RegBoostCurrent, (ph == 1) ? 16'd0 :
                (ph == 3) ? 16'hFFF : 16'($urandom_range(1300, 1800)));
      write_reg(RegNormalLimit, (ph == 5) ? 16'hFFF : 16'($urandom_range(0, 1500)));
      write_reg(RegFbThreshold, (ph == 0) ? 16'd0 : 16'($urandom_range(800, 1300)));
      write_reg(RegFbLimit, 16'($urandom_range(4095)));
      write_reg(RegBoostDur, (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 200)));
      write_reg(RegFbTrigger, (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 300)));
      write_reg(RegCoolDown, (ph == 4) ? 16'hFFFF : 16'($urandom_range(0, 300)));
      write_reg(RegResistance, (ph == 5) ? 16'hFFFF : 16'($urandom_range(0, 200)));
      if (ph == 1) write_reg(RegBoostCurrent, 16'hFFFF);
      for (int i = 0; i < 80; i++) random_tick();
      drain_all();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
